// ===== design/dpsc_pkg.sv =====
// Shared types, codes and helper functions of the damped particle step unit.
package dpsc_pkg;

  // Action codes
  localparam logic [1:0] ACT_INTEGRATE = 2'd0;
  localparam logic [1:0] ACT_COLLIDE   = 2'd1;
  localparam logic [1:0] ACT_LOAD_POS  = 2'd2;
  localparam logic [1:0] ACT_LOAD_VEL  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_DT    = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;
  localparam logic [1:0] ST_SATURATED  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_RAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z   = 3'd5;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        time_step;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] other_vel_x;
    logic signed [31:0] other_vel_y;
    logic signed [31:0] other_vel_z;
    logic [30:0]        other_radius;
    logic [31:0]        other_inv_mass;
  } dpsc_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               collided;
    logic [1:0]         status;
  } dpsc_out_t;

  // Q1.30 roots 2^-(2^-i), i = 1..16, by iterated floor square root from 0.5
  function automatic logic [15:0][30:0] exp_roots();
    logic [63:0] c;
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bit_v;
    logic [15:0][30:0] tab;
    c = 64'd1 << 29;
    for (int i = 0; i < 16; i++) begin
      n     = c << 30;
      root  = 64'd0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (n >= root + bit_v) begin
          n    = n - (root + bit_v);
          root = (root >> 1) + bit_v;
        end else begin
          root = root >> 1;
        end
        bit_v = bit_v >> 2;
      end
      c      = root;
      tab[i] = c[30:0];
    end
    return tab;
  endfunction

  // Magnitude of a two's complement word
  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Signed product from magnitude and sign, rounded to the nearest 1/65536
  function automatic logic signed [71:0] rnd16(input logic neg, input logic [63:0] mag);
    logic signed [71:0] s;
    s = $signed({8'd0, mag});
    if (neg) s = -s;
    return (s + 72'sd32768) >>> 16;
  endfunction

  // Clamp to 32 bits; MSB of the result flags a clamp
  function automatic logic [32:0] sat32(input logic signed [71:0] x);
    if (x > 72'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (x < -72'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, x[31:0]};
  endfunction

endpackage

// ===== design/damped_particle_step_with_collision_unit.sv =====
// Top level of the damped particle step unit: sequencer, shared multiplier and divider.
// One particle (Q16.16 position and velocity) is advanced one action per input transfer.
// Loads write the state directly. Integrate runs 16 squarings for the log2 of the
// damping, 16 products for the exp2, then a position and two velocity updates per axis,
// all through one 32x32 multiplier. Collide runs squares and dot products on the same
// multiplier plus up to four 35-step restoring divisions (the mass ratio and one
// projection per axis), one quotient bit per cycle. The input is stalled for the whole
// action; the result sits in an output register until the far side takes it.
module damped_particle_step_with_collision_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dpsc_pkg::dpsc_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dpsc_pkg::dpsc_out_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [dpsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import dpsc_pkg::*;

  localparam logic [31:0] OneQ = 32'(64'd1 << FRAC_BITS);
  localparam logic [15:0][30:0] ExpRoot = exp_roots();

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_I_LMUL  = 5'd2;
  localparam logic [4:0] S_I_LUPD  = 5'd3;
  localparam logic [4:0] S_I_EMUL  = 5'd4;
  localparam logic [4:0] S_I_EUPD  = 5'd5;
  localparam logic [4:0] S_I_XMUL  = 5'd6;
  localparam logic [4:0] S_I_XUPD  = 5'd7;
  localparam logic [4:0] S_I_FIN   = 5'd8;
  localparam logic [4:0] S_I_PMUL  = 5'd9;
  localparam logic [4:0] S_I_PUPD  = 5'd10;
  localparam logic [4:0] S_I_AUPD  = 5'd11;
  localparam logic [4:0] S_I_FMUL  = 5'd12;
  localparam logic [4:0] S_I_FUPD  = 5'd13;
  localparam logic [4:0] S_C_RSQ   = 5'd14;
  localparam logic [4:0] S_C_RSQ2  = 5'd15;
  localparam logic [4:0] S_C_DSQ   = 5'd16;
  localparam logic [4:0] S_C_DSQ2  = 5'd17;
  localparam logic [4:0] S_C_TEST  = 5'd18;
  localparam logic [4:0] S_DIV     = 5'd19;
  localparam logic [4:0] S_C_DOT   = 5'd20;
  localparam logic [4:0] S_C_DOT2  = 5'd21;
  localparam logic [4:0] S_C_MAG   = 5'd22;
  localparam logic [4:0] S_C_NINIT = 5'd23;
  localparam logic [4:0] S_C_NMUL  = 5'd24;
  localparam logic [4:0] S_C_NACC  = 5'd25;
  localparam logic [4:0] S_C_CMUL  = 5'd26;
  localparam logic [4:0] S_C_CACC  = 5'd27;
  localparam logic [4:0] S_C_VUPD  = 5'd28;
  localparam logic [4:0] S_DONE    = 5'd29;

  // Configuration
  logic [16:0]        damping_r;
  logic [31:0]        inv_mass_r;
  logic [30:0]        own_radius_r;
  logic signed [31:0] accel_r [3];

  // Particle state
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];

  // Control
  logic [4:0]  state_r;
  logic [1:0]  ax_r;
  logic [1:0]  part_r;
  logic [3:0]  it_r;
  dpsc_in_t    in_r;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod_r;

  // Integrate working registers
  logic [31:0]        x_r;
  logic [19:0]        lg_r;
  logic [19:0]        e_r;
  logic [30:0]        res_r;
  logic [16:0]        f_r;
  logic signed [31:0] nv_r;

  // Collide working registers
  logic [2:0]         d_neg_r;
  logic [31:0]        ad_r [3];
  logic [2:0]         vr_neg_r;
  logic [31:0]        avr_r [3];
  logic [31:0]        rsum_r;
  logic [63:0]        rsq_r;
  logic [65:0]        dsq_r;
  logic signed [66:0] dot_r;
  logic [65:0]        mag_r;
  logic               dneg_r;
  logic [31:0]        c_r;
  logic [34:0]        pm_r;
  logic [98:0]        acc_r;

  // Shared divider
  logic [63:0] div_rem_r;
  logic [34:0] div_num_r;
  logic [34:0] div_q_r;
  logic [63:0] div_den_r;
  logic [5:0]  div_cnt_r;
  logic        div_pm_r;

  // Result
  logic        sat_r;
  logic        hit_r;
  logic [1:0]  stat_r;
  logic        out_valid_r;
  dpsc_out_t   out_data_r;

  // Combinational helpers
  logic signed [31:0] in_vec [3];
  logic signed [31:0] in_ov  [3];
  logic signed [32:0] d_c    [3];
  logic signed [32:0] vr_c   [3];
  logic [31:0]        ad_c   [3];
  logic [31:0]        avr_c  [3];
  logic [3:0]         k_c;
  logic [32:0]        msum_c;
  logic [63:0]        cnum_c;
  logic               rnd_neg;
  logic signed [71:0] rnd_v;
  logic signed [71:0] upd_base;
  logic signed [71:0] upd_add;
  logic [32:0]        upd_sat;
  logic [33:0]        dm_c;
  logic               sneg_c;
  logic [64:0]        div_trial;
  logic [64:0]        div_diff;
  logic               div_ge;
  logic [63:0]        div_rem_nxt;
  logic [34:0]        div_q_nxt;
  logic [98:0]        acc_sum;
  logic [66:0]        dot_add;
  logic [30:0]        res_sh;
  logic [16:0]        f_nxt;

  // Operand and difference preparation
  always_comb begin
    in_vec[0] = in_r.vec_x;
    in_vec[1] = in_r.vec_y;
    in_vec[2] = in_r.vec_z;
    in_ov[0]  = in_r.other_vel_x;
    in_ov[1]  = in_r.other_vel_y;
    in_ov[2]  = in_r.other_vel_z;
    for (int i = 0; i < 3; i++) begin
      d_c[i]   = $signed({in_vec[i][31], in_vec[i]}) - $signed({pos_r[i][31], pos_r[i]});
      vr_c[i]  = $signed({vel_r[i][31], vel_r[i]}) - $signed({in_ov[i][31], in_ov[i]});
      ad_c[i]  = d_c[i][32] ? 32'(~d_c[i] + 33'd1) : d_c[i][31:0];
      avr_c[i] = vr_c[i][32] ? 32'(~vr_c[i] + 33'd1) : vr_c[i][31:0];
    end
    // MSB index of the damping mantissa
    k_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (damping_r[i]) k_c = 4'(i);
    end
    msum_c = {1'b0, inv_mass_r} + {1'b0, in_r.other_inv_mass};
    cnum_c = 64'({inv_mass_r, 31'd0}) + 64'(msum_c[32:1]);
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_I_LMUL: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_I_EMUL: begin
        mul_a = 32'(21'h10_0000 - {1'b0, lg_r});
        mul_b = {16'd0, in_r.time_step};
      end
      S_I_XMUL: begin
        mul_a = {1'b0, res_r};
        mul_b = e_r[4'd15 - it_r] ? {1'b0, ExpRoot[it_r]} : 32'h4000_0000;
      end
      S_I_PMUL: begin
        mul_a = abs32(vel_r[ax_r]);
        mul_b = {16'd0, in_r.time_step};
      end
      S_I_PUPD: begin
        mul_a = abs32(accel_r[ax_r]);
        mul_b = {16'd0, in_r.time_step};
      end
      S_I_FMUL: begin
        mul_a = abs32(nv_r);
        mul_b = {15'd0, f_r};
      end
      S_C_RSQ: begin
        mul_a = rsum_r;
        mul_b = rsum_r;
      end
      S_C_DSQ: begin
        mul_a = ad_r[ax_r];
        mul_b = ad_r[ax_r];
      end
      S_C_DOT: begin
        mul_a = avr_r[ax_r];
        mul_b = ad_r[ax_r];
      end
      S_C_NMUL: begin
        case (part_r)
          2'd0:    mul_a = mag_r[31:0];
          2'd1:    mul_a = mag_r[63:32];
          default: mul_a = {30'd0, mag_r[65:64]};
        endcase
        mul_b = ad_r[ax_r];
      end
      S_C_CMUL: begin
        mul_a = c_r;
        mul_b = (part_r == 2'd0) ? pm_r[31:0] : {29'd0, pm_r[34:32]};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounding, accumulate and clamp path shared by the integrate and collide state updates
  always_comb begin
    dm_c   = acc_r[63:30];
    sneg_c = dneg_r ^ d_neg_r[ax_r];
    unique case (state_r)
      S_I_PUPD: rnd_neg = vel_r[ax_r][31];
      S_I_AUPD: rnd_neg = accel_r[ax_r][31];
      default:  rnd_neg = nv_r[31];
    endcase
    rnd_v = rnd16(rnd_neg, prod_r);
    unique case (state_r)
      S_I_PUPD: begin
        upd_base = 72'(pos_r[ax_r]);
        upd_add  = rnd_v;
      end
      S_I_AUPD: begin
        upd_base = 72'(vel_r[ax_r]);
        upd_add  = rnd_v;
      end
      S_C_VUPD: begin
        upd_base = 72'(vel_r[ax_r]);
        upd_add  = sneg_c ? $signed({38'd0, dm_c}) : -$signed({38'd0, dm_c});
      end
      default: begin
        upd_base = 72'sd0;
        upd_add  = rnd_v;
      end
    endcase
    upd_sat = sat32(upd_base + upd_add);
  end

  // Restoring divider step and accumulators
  always_comb begin
    div_trial   = {div_rem_r, div_num_r[34]};
    div_diff    = div_trial - {1'b0, div_den_r};
    div_ge      = div_trial >= {1'b0, div_den_r};
    div_rem_nxt = div_ge ? div_diff[63:0] : div_trial[63:0];
    div_q_nxt   = {div_q_r[33:0], div_ge};
    case (part_r)
      2'd0:    acc_sum = acc_r + {35'd0, prod_r};
      2'd1:    acc_sum = acc_r + {3'd0, prod_r, 32'd0};
      default: acc_sum = acc_r + {prod_r[34:0], 64'd0};
    endcase
    dot_add = (vr_neg_r[ax_r] ^ d_neg_r[ax_r]) ? 67'(dot_r - $signed({3'd0, prod_r}))
                                                 : 67'(dot_r + $signed({3'd0, prod_r}));
    res_sh  = res_r >> e_r[19:16];
    f_nxt   = 17'((32'(res_sh) + 32'd8192) >> 14);
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      damping_r    <= 17'h1_0000;
      inv_mass_r   <= OneQ;
      own_radius_r <= OneQ[30:0];
      for (int i = 0; i < 3; i++) begin
        accel_r[i] <= 32'sd0;
        pos_r[i]   <= 32'sd0;
        vel_r[i]   <= 32'sd0;
      end
    end else begin
      prod_r <= mul_p;

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // Register writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_DAMPING: damping_r    <= cfg_data[16:0];
          REG_INV_MASS: inv_mass_r  <= cfg_data;
          REG_OWN_RAD: own_radius_r <= cfg_data[30:0];
          REG_ACCEL_X: accel_r[0]   <= cfg_data;
          REG_ACCEL_Y: accel_r[1]   <= cfg_data;
          REG_ACCEL_Z: accel_r[2]   <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= S_DISP;
          end
        end

        S_DISP: begin
          hit_r  <= 1'b0;
          stat_r <= ST_OK;
          sat_r  <= 1'b0;
          ax_r   <= 2'd0;
          it_r   <= 4'd0;
          unique case (in_r.action)
            ACT_LOAD_POS: begin
              for (int i = 0; i < 3; i++) pos_r[i] <= in_vec[i];
              state_r <= S_DONE;
            end
            ACT_LOAD_VEL: begin
              for (int i = 0; i < 3; i++) vel_r[i] <= in_vec[i];
              state_r <= S_DONE;
            end
            ACT_INTEGRATE: begin
              if (in_r.time_step == 16'd0) begin
                stat_r  <= ST_ZERO_DT;
                state_r <= S_DONE;
              end else if (damping_r[16]) begin
                f_r     <= 17'h1_0000;
                state_r <= S_I_PMUL;
              end else if (damping_r[15:0] == 16'd0) begin
                f_r     <= 17'd0;
                state_r <= S_I_PMUL;
              end else begin
                x_r     <= {16'd0, damping_r[15:0]} << (5'd30 - {1'b0, k_c});
                lg_r    <= {k_c, 16'd0};
                state_r <= S_I_LMUL;
              end
            end
            default: begin
              // collide: latch differences, magnitudes and signs
              for (int i = 0; i < 3; i++) begin
                ad_r[i]     <= ad_c[i];
                avr_r[i]    <= avr_c[i];
                d_neg_r[i]  <= d_c[i][32];
                vr_neg_r[i] <= vr_c[i][32];
              end
              rsum_r  <= {1'b0, own_radius_r} + {1'b0, in_r.other_radius};
              dsq_r   <= 66'd0;
              state_r <= S_C_RSQ;
            end
          endcase
        end

        // log2 of the damping by repeated squaring
        S_I_LMUL: state_r <= S_I_LUPD;
        S_I_LUPD: begin
          if (prod_r[61]) begin
            x_r                  <= {1'b0, prod_r[61:31]};
            lg_r[4'd15 - it_r]   <= 1'b1;
          end else begin
            x_r <= prod_r[61:30];
          end
          it_r    <= it_r + 4'd1;
          state_r <= (it_r == 4'd15) ? S_I_EMUL : S_I_LMUL;
        end

        // exponent scaled by the time step
        S_I_EMUL: state_r <= S_I_EUPD;
        S_I_EUPD: begin
          e_r     <= 20'((prod_r + 64'd32768) >> 16);
          res_r   <= 31'h4000_0000;
          it_r    <= 4'd0;
          state_r <= S_I_XMUL;
        end

        // exp2 of the fraction from the root table
        S_I_XMUL: state_r <= S_I_XUPD;
        S_I_XUPD: begin
          res_r   <= prod_r[60:30];
          it_r    <= it_r + 4'd1;
          state_r <= (it_r == 4'd15) ? S_I_FIN : S_I_XMUL;
        end
        S_I_FIN: begin
          f_r     <= f_nxt;
          ax_r    <= 2'd0;
          state_r <= S_I_PMUL;
        end

        // Euler step per axis
        S_I_PMUL: state_r <= S_I_PUPD;
        S_I_PUPD: begin
          pos_r[ax_r] <= upd_sat[31:0];
          sat_r       <= sat_r | upd_sat[32];
          state_r     <= S_I_AUPD;
        end
        S_I_AUPD: begin
          nv_r    <= upd_sat[31:0];
          sat_r   <= sat_r | upd_sat[32];
          state_r <= S_I_FMUL;
        end
        S_I_FMUL: state_r <= S_I_FUPD;
        S_I_FUPD: begin
          vel_r[ax_r] <= upd_sat[31:0];
          if (ax_r == 2'd2) begin
            stat_r  <= (sat_r | upd_sat[32]) ? ST_SATURATED : ST_OK;
            state_r <= S_DONE;
          end else begin
            sat_r   <= sat_r | upd_sat[32];
            ax_r    <= ax_r + 2'd1;
            state_r <= S_I_PMUL;
          end
        end

        // overlap test
        S_C_RSQ: state_r <= S_C_RSQ2;
        S_C_RSQ2: begin
          rsq_r   <= prod_r;
          ax_r    <= 2'd0;
          state_r <= S_C_DSQ;
        end
        S_C_DSQ: state_r <= S_C_DSQ2;
        S_C_DSQ2: begin
          dsq_r   <= dsq_r + {2'd0, prod_r};
          ax_r    <= ax_r + 2'd1;
          state_r <= (ax_r == 2'd2) ? S_C_TEST : S_C_DSQ;
        end
        S_C_TEST: begin
          ax_r  <= 2'd0;
          dot_r <= 67'sd0;
          if (dsq_r > {2'd0, rsq_r}) begin
            state_r <= S_DONE;
          end else if (dsq_r == 66'd0) begin
            stat_r  <= ST_COINCIDENT;
            state_r <= S_DONE;
          end else if (msum_c == 33'd0) begin
            c_r     <= 32'd0;
            state_r <= S_C_DOT;
          end else begin
            div_rem_r <= {35'd0, cnum_c[63:35]};
            div_num_r <= cnum_c[34:0];
            div_den_r <= {31'd0, msum_c};
            div_q_r   <= 35'd0;
            div_cnt_r <= 6'd0;
            div_pm_r  <= 1'b0;
            state_r   <= S_DIV;
          end
        end

        // one quotient bit per cycle
        S_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_num_r <= {div_num_r[33:0], 1'b0};
          div_q_r   <= div_q_nxt;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd34) begin
            if (div_pm_r) begin
              pm_r    <= div_q_nxt;
              acc_r   <= 99'(64'd1 << 29);
              part_r  <= 2'd0;
              state_r <= S_C_CMUL;
            end else begin
              c_r     <= div_q_nxt[31:0];
              state_r <= S_C_DOT;
            end
          end
        end

        // relative velocity dotted with the centre difference
        S_C_DOT: state_r <= S_C_DOT2;
        S_C_DOT2: begin
          dot_r   <= dot_add;
          ax_r    <= ax_r + 2'd1;
          state_r <= (ax_r == 2'd2) ? S_C_MAG : S_C_DOT;
        end
        S_C_MAG: begin
          mag_r   <= dot_r[66] ? 66'(~dot_r + 67'sd1) : dot_r[65:0];
          dneg_r  <= dot_r[66];
          ax_r    <= 2'd0;
          state_r <= S_C_NINIT;
        end

        // projection numerator per axis, then divide by |d|^2
        S_C_NINIT: begin
          acc_r   <= {34'd0, dsq_r[65:1]};
          part_r  <= 2'd0;
          state_r <= S_C_NMUL;
        end
        S_C_NMUL: state_r <= S_C_NACC;
        S_C_NACC: begin
          acc_r <= acc_sum;
          if (part_r == 2'd2) begin
            div_rem_r <= acc_sum[98:35];
            div_num_r <= acc_sum[34:0];
            div_den_r <= dsq_r[63:0];
            div_q_r   <= 35'd0;
            div_cnt_r <= 6'd0;
            div_pm_r  <= 1'b1;
            state_r   <= S_DIV;
          end else begin
            part_r  <= part_r + 2'd1;
            state_r <= S_C_NMUL;
          end
        end

        // mass ratio times projection, modulo 2^64
        S_C_CMUL: state_r <= S_C_CACC;
        S_C_CACC: begin
          acc_r <= {35'd0, acc_r[63:0] + ((part_r == 2'd0) ? prod_r : {prod_r[31:0], 32'd0})};
          if (part_r == 2'd1) begin
            state_r <= S_C_VUPD;
          end else begin
            part_r  <= 2'd1;
            state_r <= S_C_CMUL;
          end
        end
        S_C_VUPD: begin
          vel_r[ax_r] <= upd_sat[31:0];
          if (ax_r == 2'd2) begin
            hit_r   <= 1'b1;
            stat_r  <= (sat_r | upd_sat[32]) ? ST_SATURATED : ST_OK;
            state_r <= S_DONE;
          end else begin
            sat_r   <= sat_r | upd_sat[32];
            ax_r    <= ax_r + 2'd1;
            state_r <= S_C_NINIT;
          end
        end

        // hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.pos_x    <= pos_r[0];
            out_data_r.pos_y    <= pos_r[1];
            out_data_r.pos_z    <= pos_r[2];
            out_data_r.vel_x    <= vel_r[0];
            out_data_r.vel_y    <= vel_r[1];
            out_data_r.vel_z    <= vel_r[2];
            out_data_r.collided <= hit_r;
            out_data_r.status   <= stat_r;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_den_r != 64'd0)
    else $error("division started with zero divisor");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");

  a_coinc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_COINCIDENT |-> !out_data_r.collided)
    else $error("coincident centres reported as a collision");

  a_factor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_I_PMUL |-> f_r <= 17'h1_0000)
    else $error("damping factor above one");

endmodule

// ===== verif/damped_particle_step_with_collision_unit_tb.sv =====
// Self-checking testbench for the damped particle step unit with sphere collision.
`timescale 1ns / 100ps

module damped_particle_step_with_collision_unit_tb;
  import dpsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_PER_PHASE = 100;
  localparam int NUM_PHASES     = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  dpsc_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  dpsc_out_t            out_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  damped_particle_step_with_collision_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the particle state and the register file
  logic signed [31:0] pos_s[3];
  logic signed [31:0] vel_s[3];
  logic [16:0]        damping_s;
  logic [31:0]        inv_mass_s;
  logic [30:0]        own_rad_s;
  logic signed [31:0] accel_s[3];
  logic [63:0]        exp_root[16];
  bit                 clamp_hit;

  dpsc_out_t pending_results[$];
  int        fail_count;
  int        idle_cycles;
  int        send_idle_pct;
  int        stall_pct;

  // Floor square root, bit by bit from the top
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= n) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      clamp_hit = 1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      clamp_hit = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // damping^dt as Q1.16 through a log2 and an exp2 of fixed precision
  function automatic logic [16:0] damp_factor(input logic [16:0] d, input logic [15:0] t);
    logic [63:0] x, lg, e, res, q;
    int k;
    if (d >= 17'd65536) return 17'd65536;
    if (d == 0) return 17'd0;
    k = 15;
    while (k > 0 && !d[k]) k--;
    x  = 64'(d) << (30 - k);
    lg = 64'(k) << 16;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        lg[15-i] = 1'b1;
      end
    end
    e   = (((64'd16 << 16) - lg) * 64'(t) + 64'd32768) >> 16;
    q   = e >> 16;
    res = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      if (e[15-i]) res = (res * exp_root[i]) >> 30;
    end
    if (q > 31) q = 31;
    res = res >> q;
    return 17'((res + 64'd8192) >> 14);
  endfunction

  function automatic logic [1:0] euler_advance(input logic [15:0] dt);
    logic signed [127:0] acc_t;
    logic signed [31:0]  nv;
    logic [16:0]         f;
    if (dt == 0) return ST_ZERO_DT;
    clamp_hit = 0;
    f = damp_factor(damping_s, dt);
    for (int i = 0; i < 3; i++) begin
      acc_t    = vel_s[i];
      acc_t    = (acc_t * $signed({1'b0, dt}) + 32768) >>> 16;
      pos_s[i] = clamp32(pos_s[i] + acc_t);
      acc_t    = accel_s[i];
      acc_t    = (acc_t * $signed({1'b0, dt}) + 32768) >>> 16;
      nv       = clamp32(vel_s[i] + acc_t);
      acc_t    = nv;
      vel_s[i] = clamp32((acc_t * $signed({1'b0, f}) + 32768) >>> 16);
    end
    return clamp_hit ? ST_SATURATED : ST_OK;
  endfunction

  // Impulse along the centre line, scaled by the mass ratio
  function automatic logic [1:0] collide_response(input dpsc_in_t it, output logic hit);
    logic signed [127:0] dw[3], vw[3], dotp, dl;
    logic [63:0]         ad[3], rsum, c, sum, pm, dm;
    logic [127:0]        dsq, mag, num, quo;
    logic                dneg, sneg;
    hit = 0;
    dw[0] = $signed(it.vec_x) - pos_s[0];
    dw[1] = $signed(it.vec_y) - pos_s[1];
    dw[2] = $signed(it.vec_z) - pos_s[2];
    vw[0] = vel_s[0] - $signed(it.other_vel_x);
    vw[1] = vel_s[1] - $signed(it.other_vel_y);
    vw[2] = vel_s[2] - $signed(it.other_vel_z);
    rsum = 64'(own_rad_s) + 64'(it.other_radius);
    dsq  = 0;
    dotp = 0;
    for (int i = 0; i < 3; i++) begin
      ad[i] = dw[i] < 0 ? 64'(-dw[i]) : 64'(dw[i]);
      dsq   = dsq + 128'(ad[i]) * 128'(ad[i]);
      dotp  = dotp + vw[i] * dw[i];
    end
    if (dsq > 128'(rsum) * 128'(rsum)) return ST_OK;
    if (dsq == 0) return ST_COINCIDENT;
    sum  = 64'(inv_mass_s) + 64'(it.other_inv_mass);
    c    = (sum == 0) ? 64'd0 : (((64'(inv_mass_s) << 31) + (sum >> 1)) / sum);
    dneg = dotp < 0;
    mag  = dneg ? -dotp : dotp;
    clamp_hit = 0;
    for (int i = 0; i < 3; i++) begin
      sneg = dneg != (dw[i] < 0);
      num  = mag * 128'(ad[i]);
      quo  = (num + (dsq >> 1)) / dsq;
      pm   = quo[63:0];
      dm   = (c * pm + (64'd1 << 29)) >> 30;
      dl   = $signed({64'd0, dm});
      if (sneg) dl = -dl;
      vel_s[i] = clamp32(vel_s[i] - dl);
    end
    hit = 1;
    return clamp_hit ? ST_SATURATED : ST_OK;
  endfunction

  // State after one accepted action
  function automatic dpsc_out_t predict_step(input dpsc_in_t it);
    dpsc_out_t r;
    logic      hit;
    hit = 0;
    r.status = ST_OK;
    case (it.action)
      ACT_INTEGRATE: r.status = euler_advance(it.time_step);
      ACT_COLLIDE:   r.status = collide_response(it, hit);
      ACT_LOAD_POS: begin
        pos_s[0] = it.vec_x;
        pos_s[1] = it.vec_y;
        pos_s[2] = it.vec_z;
      end
      default: begin
        vel_s[0] = it.vec_x;
        vel_s[1] = it.vec_y;
        vel_s[2] = it.vec_z;
      end
    endcase
    r.pos_x = pos_s[0];
    r.pos_y = pos_s[1];
    r.pos_z = pos_s[2];
    r.vel_x = vel_s[0];
    r.vel_y = vel_s[1];
    r.vel_z = vel_s[2];
    r.collided = hit;
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver stall, changed on the falling edge
  initial begin
    out_stall = 1;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_field(input string nm, input logic [31:0] want, input logic [31:0] got);
    $display("%0t mismatch on %s: expected %h, actual %h", $time, nm, want, got);
    fail_count++;
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    dpsc_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transfer: actual %h", $time, out_data);
        fail_count++;
      end else begin
        w = pending_results.pop_front();
        if (w.pos_x !== out_data.pos_x) report_field("pos_x", w.pos_x, out_data.pos_x);
        if (w.pos_y !== out_data.pos_y) report_field("pos_y", w.pos_y, out_data.pos_y);
        if (w.pos_z !== out_data.pos_z) report_field("pos_z", w.pos_z, out_data.pos_z);
        if (w.vel_x !== out_data.vel_x) report_field("vel_x", w.vel_x, out_data.vel_x);
        if (w.vel_y !== out_data.vel_y) report_field("vel_y", w.vel_y, out_data.vel_y);
        if (w.vel_z !== out_data.vel_z) report_field("vel_z", w.vel_z, out_data.vel_z);
        if (w.collided !== out_data.collided)
          report_field("collided", w.collided, out_data.collided);
        if (w.status !== out_data.status) report_field("status", w.status, out_data.status);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One input transfer; called on a falling edge, returns on a falling edge
  task automatic send_item(input dpsc_in_t it, input bit typed, input dpsc_out_t want);
    dpsc_out_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_step(it);
    pending_results.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 0;
    case (idx)
      REG_DAMPING:  damping_s  = val[16:0];
      REG_INV_MASS: inv_mass_s = val;
      REG_OWN_RAD:  own_rad_s  = val[30:0];
      REG_ACCEL_X:  accel_s[0] = val;
      REG_ACCEL_Y:  accel_s[1] = val;
      default:      accel_s[2] = val;
    endcase
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  // Mostly overlapping contacts and real steps, with some full-range noise
  function automatic dpsc_in_t random_item();
    dpsc_in_t it;
    int sel;
    it.action         = 2'($urandom_range(3));
    it.time_step      = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
    it.vec_x          = rand_word();
    it.vec_y          = rand_word();
    it.vec_z          = rand_word();
    it.other_vel_x    = rand_word();
    it.other_vel_y    = rand_word();
    it.other_vel_z    = rand_word();
    it.other_radius   = 31'($urandom) >> $urandom_range(0, 30);
    it.other_inv_mass = $urandom >> $urandom_range(0, 31);
    if (it.other_inv_mass == 0) it.other_inv_mass = 1;
    sel = $urandom_range(9);
    if (sel < 3) it.action = ACT_INTEGRATE;
    else if (sel < 8) it.action = ACT_COLLIDE;
    if (it.action == ACT_COLLIDE && $urandom_range(3) != 0) begin
      it.vec_x = pos_s[0] + ($signed($urandom) >>> $urandom_range(12, 31));
      it.vec_y = pos_s[1] + ($signed($urandom) >>> $urandom_range(12, 31));
      it.vec_z = pos_s[2] + ($signed($urandom) >>> $urandom_range(12, 31));
      if ($urandom_range(7) == 0) begin
        it.vec_x = pos_s[0];
        it.vec_y = pos_s[1];
        it.vec_z = pos_s[2];
      end
    end
    return it;
  endfunction

  typedef struct {
    dpsc_in_t  item;
    bit        typed;
    dpsc_out_t want;
  } dir_row_t;

  initial begin
    dir_row_t  dir_tab[$];
    dpsc_out_t none;
    logic [63:0] c;
    logic [16:0] damp_set[NUM_PHASES];
    logic [31:0] imass_set[NUM_PHASES];
    logic [30:0] rad_set[NUM_PHASES];
    logic [31:0] acc_set[NUM_PHASES];

    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_wr_en = 0;
    cfg_index = REG_DAMPING;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    send_idle_pct = 36;
    stall_pct = 86;
    none = '0;

    // exp2 constants: repeated floor square roots from one half
    c = 64'd1 << 29;
    for (int i = 0; i < 16; i++) begin
      c = floor_sqrt(c << 30);
      exp_root[i] = c;
    end

    damping_s  = 17'd65536;
    inv_mass_s = 32'd65536;
    own_rad_s  = 31'd65536;
    for (int i = 0; i < 3; i++) begin
      pos_s[i]   = 0;
      vel_s[i]   = 0;
      accel_s[i] = 0;
    end

    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed table: reset state, extremes, every action and the special cases
    dir_tab.push_back('{dpsc_in_t'{action: ACT_INTEGRATE, default: '0}, 1,
                        dpsc_out_t'{status: ST_ZERO_DT, default: '0}});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_LOAD_POS, vec_x: 32'h7FFF_FFFF,
                        vec_y: 32'h8000_0000, vec_z: 32'h0001_0000, default: '0}, 1,
                        dpsc_out_t'{pos_x: 32'h7FFF_FFFF, pos_y: 32'h8000_0000,
                        pos_z: 32'h0001_0000, default: '0}});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_LOAD_VEL, vec_x: 32'h7FFF_FFFF,
                        vec_y: 32'h8000_0000, vec_z: 32'hFFFF_0000, default: '0}, 0, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_INTEGRATE, time_step: 16'hFFFF,
                        default: '0}, 0, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_INTEGRATE, time_step: 16'h0001,
                        default: '0}, 0, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_LOAD_POS, default: '0}, 0, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_LOAD_VEL, default: '0}, 1, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_COLLIDE, other_radius: 31'h7FFF_FFFF,
                        other_inv_mass: 32'hFFFF_FFFF, default: '0}, 1,
                        dpsc_out_t'{status: ST_COINCIDENT, default: '0}});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_COLLIDE, vec_x: 32'h7FFF_FFFF,
                        other_inv_mass: 32'd1, default: '0}, 1, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_LOAD_VEL, vec_x: 32'h0003_0000,
                        vec_y: 32'hFFFE_0000, vec_z: 32'h0000_8000, default: '0}, 0, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_COLLIDE, vec_x: 32'h0000_8000,
                        vec_y: 32'h0000_4000, other_vel_x: 32'hFFFF_0000,
                        other_radius: 31'h0001_0000, other_inv_mass: 32'h0001_0000,
                        default: '0}, 0, none});
    // just touching: distance equals the summed radii
    dir_tab.push_back('{dpsc_in_t'{action: ACT_COLLIDE, vec_x: 32'h0001_0000,
                        other_vel_x: 32'h8000_0000, other_vel_y: 32'h7FFF_FFFF,
                        other_vel_z: 32'h8000_0000, other_inv_mass: 32'hFFFF_FFFF,
                        default: '0}, 0, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_COLLIDE, vec_x: 32'h8000_0000,
                        vec_y: 32'h8000_0000, vec_z: 32'h8000_0000,
                        other_vel_x: 32'h7FFF_FFFF, other_vel_y: 32'h7FFF_FFFF,
                        other_vel_z: 32'h7FFF_FFFF, other_radius: 31'h7FFF_FFFF,
                        other_inv_mass: 32'd1, default: '0}, 0, none});
    dir_tab.push_back('{dpsc_in_t'{action: ACT_INTEGRATE, time_step: 16'h8000,
                        default: '0}, 0, none});

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    // Register settings per phase, extremes included
    damp_set  = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd32768, 17'd65535};
    imass_set = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'd300, 32'h0010_0000, 32'h8000_0000};
    rad_set   = '{31'd65536, 31'd0, 31'h7FFF_FFFF, 31'h0000_4000, 31'h0100_0000, 31'd1};
    acc_set   = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0009_CCCC, 32'hFFF6_3333, 32'd1};

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      send_idle_pct = (p < 2) ? 36 : (p < 4) ? 86 : 0;
      stall_pct     = (p < 2) ? 86 : (p < 4) ? 36 : 0;
      write_reg(REG_DAMPING, (p == 3) ? 32'($urandom_range(65535)) : 32'(damp_set[p]));
      write_reg(REG_INV_MASS, imass_set[p]);
      write_reg(REG_OWN_RAD, 32'(rad_set[p]));
      write_reg(REG_ACCEL_X, acc_set[p]);
      write_reg(REG_ACCEL_Y, acc_set[(p + 1) % NUM_PHASES]);
      write_reg(REG_ACCEL_Z, (p == 5) ? $urandom : acc_set[(p + 2) % NUM_PHASES]);
      repeat (RAND_PER_PHASE) send_item(random_item(), 0, none);
    end

    in_valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== damped_particle_step_with_collision_unit.f =====
design/dpsc_pkg.sv
design/damped_particle_step_with_collision_unit.sv
verif/damped_particle_step_with_collision_unit_tb.sv
